/* hw/rtl/link_controller_register_file_unit_assert.svh */
// assertion macros used by the link controller register file checker
`ifndef LINK_CONTROLLER_REGISTER_FILE_UNIT_ASSERT_SVH
`define LINK_CONTROLLER_REGISTER_FILE_UNIT_ASSERT_SVH

// clocked assertion, switched off while reset is asserted
`define LCRF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LCRF_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lcrf_pkg.sv */
// shared types, constants and helpers of the link controller register file
package lcrf_pkg;

  localparam int WINDOW_WORDS = 16384;
  localparam int PHY_REGS     = 16;

  localparam int OFS_W    = 14;
  localparam int DATA_W   = 32;
  localparam int PHY_W    = 8;
  localparam int STORE_AW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
  localparam int PHY_AW   = $clog2(PHY_REGS);
  localparam int WRAP_MAX = ((1 << OFS_W) + WINDOW_WORDS - 1) / WINDOW_WORDS;

  // decoded word offsets
  localparam logic [OFS_W-1:0] OFS_NODE_ID = 14'h2100;
  localparam logic [OFS_W-1:0] OFS_CTRL0   = 14'h2102;
  localparam logic [OFS_W-1:0] OFS_CTRL2   = 14'h2104;
  localparam logic [OFS_W-1:0] OFS_PHY_ACC = 14'h2105;
  localparam logic [OFS_W-1:0] OFS_INT0    = 14'h2108;
  localparam logic [OFS_W-1:0] OFS_MASK0   = 14'h2109;
  localparam logic [OFS_W-1:0] OFS_INT1    = 14'h210A;
  localparam logic [OFS_W-1:0] OFS_INT2    = 14'h210C;
  localparam logic [OFS_W-1:0] OFS_MAGIC   = 14'h211F;

  // store rows of the registers touched by the phy read sequence
  localparam logic [STORE_AW-1:0] IDX_INT0  = STORE_AW'(int'(OFS_INT0) % WINDOW_WORDS);
  localparam logic [STORE_AW-1:0] IDX_MASK0 = STORE_AW'(int'(OFS_MASK0) % WINDOW_WORDS);

  // fixed values and bit masks
  localparam logic [DATA_W-1:0] NODE_ID_VAL  = 32'hffc00001;
  localparam logic [DATA_W-1:0] MAGIC_VAL    = 32'h10000001;
  localparam logic [DATA_W-1:0] PHY_IRQ_BIT  = 32'h40000000;
  localparam logic [DATA_W-1:0] PHY_RD_BIT   = 32'h80000000;
  localparam logic [DATA_W-1:0] PHY_WR_CLR   = 32'h4000ffff;
  localparam logic [DATA_W-1:0] CTRL0_CLR    = 32'h00800000;
  localparam logic [DATA_W-1:0] CTRL2_VAL    = 32'h00000008;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_INT  = 7'b0001000,
    S_MASK = 7'b0010000,
    S_IRQ  = 7'b0100000,
    S_OUT  = 7'b1000000
  } lcrf_state_t;

  // word offset folded onto the store depth, by parallel threshold compares
  function automatic logic [STORE_AW-1:0] store_idx(input logic [OFS_W-1:0] ofs);
    logic [OFS_W-1:0] base;
    base = '0;
    for (int k = 1; k < WRAP_MAX; k++) begin
      if (ofs >= OFS_W'(k * WINDOW_WORDS)) base = OFS_W'(k * WINDOW_WORDS);
    end
    return STORE_AW'(ofs - base);
  endfunction

endpackage

/* hw/rtl/lcrf_in_if.sv */
// request channel: access type, word offset and write data
interface lcrf_in_if import lcrf_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [OFS_W-1:0]  word_offset;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, output func, output word_offset, output wdata, input ready);
  modport sink   (input valid, input func, input word_offset, input wdata, output ready);
endinterface

/* hw/rtl/lcrf_out_if.sv */
// response channel: read data and interrupt flag
interface lcrf_out_if import lcrf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic              irq;

  modport source (output valid, output rdata, output irq, input ready);
  modport sink   (input valid, input rdata, input irq, output ready);
endinterface

/* hw/rtl/lcrf_ram.sv */
// generic single-write, single-read ram with registered read data
module lcrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/link_controller_register_file_unit.sv */
// link controller register window: one store ram, phy byte store and access sequencer
// plain writes can be taken back to back while the response sink keeps up; reads,
// write-one-to-clear and phy reads hold off the next request, set by the store ram read-modify-write
//   (one read port, one write port, read data registered, in the cycle after the address)
// reset: synchronous active-low rst_n, then a clearing pass over every store row
//   zeroes the store while in_ch.ready stays low
module link_controller_register_file_unit import lcrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lcrf_in_if.sink    in_ch,
  lcrf_out_if.source out_ch
);

  // sequencer state
  lcrf_state_t         state_r, state_nxt;
  logic [STORE_AW-1:0] clr_idx_r, clr_idx_nxt;

  // held request fields for multi-cycle sequences
  logic [STORE_AW-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0]   wdata_r, wdata_nxt;
  logic                fix_en_r, fix_en_nxt;     // read of a fixed-value offset
  logic                fix_node_r, fix_node_nxt; // node id rather than magic word

  // result waiting for the output register
  logic [DATA_W-1:0]   pend_rdata_r, pend_rdata_nxt;
  logic                pend_irq_r, pend_irq_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_rdata_r, out_rdata_nxt;
  logic                out_irq_r, out_irq_nxt;

  // phy byte store, small enough for flops
  logic [PHY_W-1:0]    phy_r [PHY_REGS];
  logic                phy_we;

  // store ram ports
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [STORE_AW-1:0] ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  // sequence completion
  logic                fin;
  logic [DATA_W-1:0]   fin_rdata;
  logic                fin_irq;

  logic                in_ready;
  logic                in_fire;
  logic                slot_free;
  logic [STORE_AW-1:0] in_idx;
  logic [PHY_AW-1:0]   phy_rd_entry;
  logic [PHY_W-1:0]    phy_rd_byte;

  lcrf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_fire   = in_ch.valid && in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  // decode uses the full offset, the store row wraps onto the ram depth
  assign in_idx    = store_idx(in_ch.word_offset);

  // phy read mode picks the entry from access word bits 27:24
  assign phy_rd_entry = in_ch.wdata[24 +: PHY_AW];
  assign phy_rd_byte  = phy_r[phy_rd_entry];

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    idx_nxt      = idx_r;
    wdata_nxt    = wdata_r;
    fix_en_nxt   = fix_en_r;
    fix_node_nxt = fix_node_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = '0;
    ram_raddr    = idx_r;
    phy_we       = 1'b0;
    fin          = 1'b0;
    fin_rdata    = '0;
    fin_irq      = 1'b0;
    in_ready     = 1'b0;

    unique case (state_r)
      // zero one store row per cycle after reset
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
        if (clr_idx_r == STORE_AW'(WINDOW_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + STORE_AW'(1);
        end
      end

      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_idx;
        ram_waddr = in_idx;
        if (in_fire) begin
          idx_nxt   = in_idx;
          wdata_nxt = in_ch.wdata;
          if (!in_ch.func) begin
            // read: store word arrives next cycle, fixed offsets override it
            fix_en_nxt   = (in_ch.word_offset == OFS_NODE_ID) ||
                           (in_ch.word_offset == OFS_MAGIC);
            fix_node_nxt = (in_ch.word_offset == OFS_NODE_ID);
            state_nxt    = S_RD;
          end else begin
            unique case (in_ch.word_offset) inside
              OFS_PHY_ACC: begin
                ram_we = 1'b1;
                if (in_ch.wdata[30]) begin
                  // phy write mode wins over read mode
                  phy_we    = 1'b1;
                  ram_wdata = in_ch.wdata & ~PHY_WR_CLR;
                  fin       = 1'b1;
                end else if (in_ch.wdata[31]) begin
                  // phy read mode: byte and entry number folded into the access word,
                  // then look at mask-0 to decide on the interrupt
                  ram_wdata = (in_ch.wdata & ~PHY_RD_BIT) |
                              {20'b0, in_ch.wdata[27:24], phy_rd_byte};
                  ram_raddr = IDX_MASK0;
                  state_nxt = S_MASK;
                end else begin
                  ram_wdata = in_ch.wdata;
                  fin       = 1'b1;
                end
              end
              OFS_CTRL0: begin
                ram_we    = 1'b1;
                ram_wdata = in_ch.wdata & ~CTRL0_CLR;
                fin       = 1'b1;
              end
              OFS_CTRL2: begin
                ram_we    = 1'b1;
                ram_wdata = CTRL2_VAL;
                fin       = 1'b1;
              end
              OFS_INT0, OFS_INT1, OFS_INT2: begin
                // write-one-to-clear needs the old word first
                state_nxt = S_INT;
              end
              default: begin
                ram_we    = 1'b1;
                ram_wdata = in_ch.wdata;
                fin       = 1'b1;
              end
            endcase
          end
        end
      end

      S_RD: begin
        fin       = 1'b1;
        fin_rdata = !fix_en_r ? ram_rdata : (fix_node_r ? NODE_ID_VAL : MAGIC_VAL);
      end

      S_INT: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~wdata_r;
        fin       = 1'b1;
      end

      S_MASK: begin
        if (ram_rdata[30]) begin
          ram_raddr = IDX_INT0;
          state_nxt = S_IRQ;
        end else begin
          fin = 1'b1;
        end
      end

      S_IRQ: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_INT0;
        ram_wdata = ram_rdata | PHY_IRQ_BIT;
        fin       = 1'b1;
        fin_irq   = 1'b1;
      end

      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // output register and parking slot for a result that meets a stalled sink
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_rdata_nxt  = out_rdata_r;
    out_irq_nxt    = out_irq_r;
    pend_rdata_nxt = pend_rdata_r;
    pend_irq_nxt   = pend_irq_r;

    if (state_r == S_OUT && slot_free) begin
      out_valid_nxt = 1'b1;
      out_rdata_nxt = pend_rdata_r;
      out_irq_nxt   = pend_irq_r;
    end else if (fin) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_rdata_nxt = fin_rdata;
        out_irq_nxt   = fin_irq;
      end else begin
        pend_rdata_nxt = fin_rdata;
        pend_irq_nxt   = fin_irq;
      end
    end
  end

  // a finished sequence either loads the output or waits in the parking state
  lcrf_state_t state_fin;
  always_comb begin
    state_fin = state_nxt;
    if (fin) begin
      state_fin = slot_free ? S_IDLE : S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      fix_en_r    <= 1'b0;
      fix_node_r  <= 1'b0;
      for (int i = 0; i < PHY_REGS; i++) begin
        phy_r[i] <= '0;
      end
    end else begin
      state_r     <= state_fin;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      fix_en_r    <= fix_en_nxt;
      fix_node_r  <= fix_node_nxt;
      if (phy_we) begin
        phy_r[in_ch.wdata[8 +: PHY_AW]] <= in_ch.wdata[PHY_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    wdata_r      <= wdata_nxt;
    pend_rdata_r <= pend_rdata_nxt;
    pend_irq_r   <= pend_irq_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_irq_r    <= out_irq_nxt;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.rdata = out_rdata_r;
  assign out_ch.irq   = out_irq_r;

endmodule

/* hw/rtl/lcrf_checker.sv */
// port-level checker for the link controller register file, bound to the top level
`include "link_controller_register_file_unit_assert.svh"

module lcrf_checker import lcrf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_rdata,
  input logic              out_irq
);

  // a held response keeps its payload
  `LCRF_ASSERT_CLK(a_out_stable, clk, rst_n, (out_valid && !out_ready) |=> ($stable(out_rdata) && $stable(out_irq)), "response payload changed while stalled")

  // a held response stays valid
  `LCRF_ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "response dropped while stalled")

  // the store clearing pass keeps requests out right after reset
  `LCRF_ASSERT_CLK(a_clr_blocks, clk, rst_n, $rose(rst_n) |-> !in_ready, "request taken during clearing pass")

  // a read waits for the registered store data, so the next request cannot follow at once
  `LCRF_ASSERT_CLK(a_read_busy, clk, rst_n, (in_valid && in_ready && !in_func) |=> !in_ready, "request taken while a read is in flight")

  // reset empties the output register
  `LCRF_ASSERT_ANY(a_rst_out, clk, !rst_n |=> !out_valid, "response valid after reset")

endmodule

bind link_controller_register_file_unit lcrf_checker u_lcrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rdata (out_ch.rdata),
  .out_irq   (out_ch.irq)
);
